// ===== hw/rtl/spi_pkg.sv =====
// Shared types, widths, register indexes and arithmetic helpers for the
// segment / plane intersection block. Depends on nothing; every other file
// imports it.
package spi_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int LEN_W     = COORD_W - 1;
    localparam int MARGIN_W  = 16;
    localparam int UNIT_W    = FRAC_W + 2;
    localparam int NRM_W     = 30;
    localparam int SHIFT_MAX = COORD_W - NRM_W;
    localparam int SHIFT_W   = $clog2(SHIFT_MAX + 1);
    localparam int SUM_W     = 2 * NRM_W + 2;
    localparam int ROOT_W    = NRM_W + 1;
    localparam int NUM_W     = NRM_W + FRAC_W + 1;
    localparam int QUO_W     = FRAC_W + 1;
    localparam int NORM_LAT  = 4 + ROOT_W + 1 + QUO_W;
    localparam int FRONT_LAT = NORM_LAT + 5;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int E_W       = COORD_W + 3;
    localparam int P_W       = UNIT_W + E_W - FRAC_W + 2;
    localparam int SAT_W     = P_W + 2;
    localparam int REM_W     = COORD_W + 3;
    localparam int BACK_N    = FRAC_W + 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN   = 3'd6;

    localparam logic signed [COORD_W-1:0] ONE_Q = COORD_W'(1) << FRAC_W;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(7);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [UNIT_W-1:0]  unit_t;
    typedef coord_t [2:0] cvec_t;
    typedef unit_t  [2:0] uvec_t;

    typedef struct packed {
        coord_t             start_x;
        coord_t             start_y;
        coord_t             start_z;
        coord_t             dir_x;
        coord_t             dir_y;
        coord_t             dir_z;
        logic [LEN_W-1:0]   seg_length;
    } seg_t;

    typedef struct packed {
        logic   hit;
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
    } res_t;

    typedef struct packed {
        cvec_t            st;
        logic [LEN_W-1:0] len;
    } side_t;

    typedef struct packed {
        logic                      hit;
        coord_t                    p1;
        logic signed [DIFF_W-1:0]  den;
        cvec_t                     st;
        uvec_t                     dn;
        logic [LEN_W-1:0]          len;
    } job_t;

    typedef struct packed {
        logic full;
        logic avail;
    } q_status_t;

    // Fixed-point product of a unit-range value and a wide value, rounded
    // half away from zero at the binary point.
    function automatic logic signed [P_W-1:0] qmul_unit(input unit_t u,
                                                       input logic signed [E_W-1:0] x);
        logic [UNIT_W-1:0]     mu;
        logic [E_W-1:0]        mx;
        logic [UNIT_W+E_W:0]   prod;
        logic [UNIT_W+E_W:0]   half;
        logic [P_W-1:0]        r;
        mu   = u[UNIT_W-1] ? UNIT_W'(-u) : UNIT_W'(u);
        mx   = x[E_W-1] ? E_W'(-x) : E_W'(x);
        half = '0;
        half[FRAC_W-1] = 1'b1;
        prod = {{(E_W+1){1'b0}}, mu} * {{(UNIT_W+1){1'b0}}, mx};
        prod = prod + half;
        r    = P_W'(prod >> FRAC_W);
        return (u[UNIT_W-1] ^ x[E_W-1]) ? -$signed(r) : $signed(r);
    endfunction

    function automatic coord_t sat_coord(input logic signed [SAT_W-1:0] x);
        if (x[SAT_W-1:COORD_W-1] == '0 || x[SAT_W-1:COORD_W-1] == '1)
            return x[COORD_W-1:0];
        else if (x[SAT_W-1])
            return {1'b1, {(COORD_W-1){1'b0}}};
        else
            return {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

endpackage

// ===== hw/rtl/spi_norm.sv =====
// Pipelined vector normaliser: magnitude, range shift, squares, square root
// one bit a stage, then rounded division one quotient bit a stage.
// Depends on spi_pkg.
module spi_norm
    import spi_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  cvec_t vec,
    output uvec_t unit
);

    logic [2:0]         s1_sgn_reg;
    logic [COORD_W-1:0] s1_mag_reg [3];
    logic [2:0]         s2_sgn_reg;
    logic [NRM_W-1:0]   s2_a_reg [3];
    logic [2:0]         s3_sgn_reg;
    logic [NRM_W-1:0]   s3_a_reg [3];
    logic [2*NRM_W-1:0] s3_sq_reg [3];

    logic [SUM_W-1:0]  rt_rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] rt_root_reg [ROOT_W+1];
    logic [NRM_W-1:0]  rt_a_reg    [ROOT_W+1][3];
    logic [2:0]        rt_sgn_reg  [ROOT_W+1];
    logic [SUM_W-1:0]  rt_rem_next  [ROOT_W+1];
    logic [ROOT_W-1:0] rt_root_next [ROOT_W+1];

    logic [NUM_W-1:0]  dv_rem_reg [QUO_W+1][3];
    logic [QUO_W-1:0]  dv_quo_reg [QUO_W+1][3];
    logic [ROOT_W-1:0] dv_q_reg   [QUO_W+1];
    logic [2:0]        dv_sgn_reg [QUO_W+1];
    logic [NUM_W-1:0]  dv_rem_next [QUO_W+1][3];
    logic [QUO_W-1:0]  dv_quo_next [QUO_W+1][3];

    logic [SHIFT_W-1:0] shift;

    // Least shift that brings the largest magnitude below the range limit.
    always_comb
    begin
        logic [COORD_W-1:0] m;
        m = s1_mag_reg[0];
        if (s1_mag_reg[1] > m)
            m = s1_mag_reg[1];
        if (s1_mag_reg[2] > m)
            m = s1_mag_reg[2];
        shift = SHIFT_W'(SHIFT_MAX);
        for (int k = SHIFT_MAX; k >= 0; k--)
        begin
            if ((m >> k) < (COORD_W'(1) << NRM_W))
                shift = SHIFT_W'(k);
        end
    end

    // Square root, one result bit per stage.
    always_comb
    begin
        logic [SUM_W+1:0] inc;
        rt_rem_next[0]  = rt_rem_reg[0];
        rt_root_next[0] = rt_root_reg[0];
        for (int j = 1; j <= ROOT_W; j++)
        begin
            inc = ((SUM_W+2)'(rt_root_reg[j-1]) << (ROOT_W - j + 1))
                + ((SUM_W+2)'(1) << (2 * (ROOT_W - j)));
            if ({2'b00, rt_rem_reg[j-1]} >= inc)
            begin
                rt_rem_next[j]  = rt_rem_reg[j-1] - SUM_W'(inc);
                rt_root_next[j] = rt_root_reg[j-1] | (ROOT_W'(1) << (ROOT_W - j));
            end
            else
            begin
                rt_rem_next[j]  = rt_rem_reg[j-1];
                rt_root_next[j] = rt_root_reg[j-1];
            end
        end
    end

    // Restoring division, one quotient bit per stage.
    always_comb
    begin
        logic [NUM_W:0] trial;
        for (int i = 0; i < 3; i++)
        begin
            dv_rem_next[0][i] = (NUM_W'(rt_a_reg[ROOT_W][i]) << FRAC_W)
                              + NUM_W'(rt_root_reg[ROOT_W] >> 1);
            dv_quo_next[0][i] = '0;
        end
        for (int j = 1; j <= QUO_W; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial = (NUM_W+1)'(dv_q_reg[j-1]) << (QUO_W - j);
                if (dv_q_reg[j-1] != '0 && {1'b0, dv_rem_reg[j-1][i]} >= trial)
                begin
                    dv_rem_next[j][i] = dv_rem_reg[j-1][i] - NUM_W'(trial);
                    dv_quo_next[j][i] = dv_quo_reg[j-1][i] | (QUO_W'(1) << (QUO_W - j));
                end
                else
                begin
                    dv_rem_next[j][i] = dv_rem_reg[j-1][i];
                    dv_quo_next[j][i] = dv_quo_reg[j-1][i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_sgn_reg[i] <= vec[i][COORD_W-1];
                s1_mag_reg[i] <= vec[i][COORD_W-1] ? COORD_W'(-vec[i]) : COORD_W'(vec[i]);
                s2_a_reg[i]   <= NRM_W'(s1_mag_reg[i] >> shift);
                s3_a_reg[i]   <= s2_a_reg[i];
                s3_sq_reg[i]  <= {{NRM_W{1'b0}}, s2_a_reg[i]} * {{NRM_W{1'b0}}, s2_a_reg[i]};
                rt_a_reg[0][i] <= s3_a_reg[i];
            end
            s2_sgn_reg <= s1_sgn_reg;
            s3_sgn_reg <= s2_sgn_reg;
            rt_sgn_reg[0]  <= s3_sgn_reg;
            rt_rem_reg[0]  <= SUM_W'(s3_sq_reg[0]) + SUM_W'(s3_sq_reg[1])
                            + SUM_W'(s3_sq_reg[2]);
            rt_root_reg[0] <= '0;
            for (int j = 1; j <= ROOT_W; j++)
            begin
                rt_rem_reg[j]  <= rt_rem_next[j];
                rt_root_reg[j] <= rt_root_next[j];
                rt_a_reg[j]    <= rt_a_reg[j-1];
                rt_sgn_reg[j]  <= rt_sgn_reg[j-1];
            end
            dv_rem_reg[0] <= dv_rem_next[0];
            dv_quo_reg[0] <= dv_quo_next[0];
            dv_q_reg[0]   <= rt_root_reg[ROOT_W];
            dv_sgn_reg[0] <= rt_sgn_reg[ROOT_W];
            for (int j = 1; j <= QUO_W; j++)
            begin
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_quo_reg[j] <= dv_quo_next[j];
                dv_q_reg[j]   <= dv_q_reg[j-1];
                dv_sgn_reg[j] <= dv_sgn_reg[j-1];
            end
        end
    end

    always_comb
    begin
        unit_t uq;
        for (int i = 0; i < 3; i++)
        begin
            uq = unit_t'({1'b0, dv_quo_reg[QUO_W][i]});
            unit[i] = dv_sgn_reg[QUO_W][i] ? -uq : uq;
        end
    end

endmodule

// ===== hw/rtl/spi_front.sv =====
// Front part: accepts segments, normalises direction and plane normal,
// forms both plane distances and classifies the crossing.
// Depends on spi_pkg and spi_norm.
module spi_front
    import spi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                seg_valid,
    input  seg_t                seg,
    output logic                seg_stall,
    input  cvec_t               normal,
    input  cvec_t               plane_point,
    input  logic [MARGIN_W-1:0] margin,
    input  q_status_t           q_status,
    output logic                push,
    output job_t                job
);

    logic [FRONT_LAT-1:0] vld_reg;
    side_t                side_reg [NORM_LAT];
    logic                 en;
    cvec_t                dir_vec;
    uvec_t                dir_unit;
    uvec_t                nrm_unit;

    cvec_t                    f1_st_reg, f2_st_reg, f3_st_reg, f4_st_reg;
    uvec_t                    f1_dn_reg, f2_dn_reg, f3_dn_reg, f4_dn_reg;
    uvec_t                    f1_nn_reg, f2_nn_reg;
    logic [LEN_W-1:0]         f1_len_reg, f2_len_reg, f3_len_reg, f4_len_reg;
    logic signed [DIFF_W-1:0] f1_d_reg [3];
    logic signed [P_W-1:0]    f1_ml_reg [3];
    logic signed [DIFF_W-1:0] f2_d_reg [3];
    logic signed [E_W-1:0]    f2_e_reg [3];
    logic signed [P_W-1:0]    f3_pd_reg [3];
    logic signed [P_W-1:0]    f3_pe_reg [3];
    coord_t                   f4_p1_reg, f4_p2_reg;
    job_t                     job_reg;
    coord_t                   eps;

    // Advance unless the last stage holds an item that the queue cannot take.
    assign en        = !(vld_reg[FRONT_LAT-1] && q_status.full);
    assign seg_stall = !en;
    assign push      = en && vld_reg[FRONT_LAT-1];
    assign job       = job_reg;
    assign dir_vec   = {seg.dir_z, seg.dir_y, seg.dir_x};
    assign eps       = coord_t'({{(COORD_W-MARGIN_W){1'b0}}, margin});

    spi_norm u_dir_norm (
        .clk  (clk),
        .en   (en),
        .vec  (dir_vec),
        .unit (dir_unit)
    );

    spi_norm u_nrm_norm (
        .clk  (clk),
        .en   (en),
        .vec  (normal),
        .unit (nrm_unit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[FRONT_LAT-2:0], seg_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= '{st: {seg.start_z, seg.start_y, seg.start_x},
                             len: seg.seg_length};
            for (int k = 1; k < NORM_LAT; k++)
                side_reg[k] <= side_reg[k-1];

            // Offset from the plane point and the travel along the direction.
            f1_st_reg  <= side_reg[NORM_LAT-1].st;
            f1_len_reg <= side_reg[NORM_LAT-1].len;
            f1_dn_reg  <= dir_unit;
            f1_nn_reg  <= nrm_unit;
            for (int i = 0; i < 3; i++)
            begin
                f1_d_reg[i]  <= DIFF_W'($signed(side_reg[NORM_LAT-1].st[i]))
                              - DIFF_W'($signed(plane_point[i]));
                f1_ml_reg[i] <= qmul_unit(dir_unit[i],
                                          E_W'(side_reg[NORM_LAT-1].len));
            end

            // End point offset.
            f2_st_reg  <= f1_st_reg;
            f2_len_reg <= f1_len_reg;
            f2_dn_reg  <= f1_dn_reg;
            f2_nn_reg  <= f1_nn_reg;
            for (int i = 0; i < 3; i++)
            begin
                f2_d_reg[i] <= f1_d_reg[i];
                f2_e_reg[i] <= E_W'(f1_d_reg[i]) + E_W'(f1_ml_reg[i]);
            end

            // Per-axis terms of both dot products.
            f3_st_reg  <= f2_st_reg;
            f3_len_reg <= f2_len_reg;
            f3_dn_reg  <= f2_dn_reg;
            for (int i = 0; i < 3; i++)
            begin
                f3_pd_reg[i] <= qmul_unit(f2_nn_reg[i], E_W'(f2_d_reg[i]));
                f3_pe_reg[i] <= qmul_unit(f2_nn_reg[i], f2_e_reg[i]);
            end

            // Sum and saturate the distances.
            f4_st_reg  <= f3_st_reg;
            f4_len_reg <= f3_len_reg;
            f4_dn_reg  <= f3_dn_reg;
            f4_p1_reg  <= sat_coord(SAT_W'(f3_pd_reg[0]) + SAT_W'(f3_pd_reg[1])
                                    + SAT_W'(f3_pd_reg[2]));
            f4_p2_reg  <= sat_coord(SAT_W'(f3_pe_reg[0]) + SAT_W'(f3_pe_reg[1])
                                    + SAT_W'(f3_pe_reg[2]));

            // Classify: front-to-back crossing only.
            job_reg.hit <= (f4_p1_reg >= eps) && (f4_p2_reg <= -eps);
            job_reg.p1  <= f4_p1_reg;
            job_reg.den <= DIFF_W'(f4_p1_reg) - DIFF_W'(f4_p2_reg);
            job_reg.st  <= f4_st_reg;
            job_reg.dn  <= f4_dn_reg;
            job_reg.len <= f4_len_reg;
        end
    end

endmodule

// ===== hw/rtl/spi_queue.sv =====
// Short queue of classified items between the front and back parts.
// Depends on spi_pkg.
module spi_queue
    import spi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      wr_job,
    input  logic      pop,
    output job_t      rd_job,
    output q_status_t status
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign rd_job       = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign status.avail = (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

// ===== hw/rtl/spi_back.sv =====
// Back part: crossing ratio by long division, travel distance, offset along
// the direction and the saturated result register.
// Depends on spi_pkg.
module spi_back
    import spi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      job,
    input  q_status_t q_status,
    output logic      pop,
    output logic      res_valid,
    input  logic      res_stall,
    output res_t      res
);

    logic             dv_hit_reg [FRAC_W+1];
    cvec_t            dv_st_reg  [FRAC_W+1];
    uvec_t            dv_dn_reg  [FRAC_W+1];
    logic [LEN_W-1:0] dv_len_reg [FRAC_W+1];
    logic [DIFF_W-1:0] dv_den_reg [FRAC_W+1];
    logic [REM_W-1:0] dv_rem_reg [FRAC_W+1];
    logic [FRAC_W-1:0] dv_t_reg  [FRAC_W+1];
    logic [REM_W-1:0] dv_rem_next [FRAC_W+1];
    logic [FRAC_W-1:0] dv_t_next  [FRAC_W+1];

    logic             rd_hit_reg;
    cvec_t            rd_st_reg;
    uvec_t            rd_dn_reg;
    logic [LEN_W-1:0] rd_len_reg;
    logic [QUO_W-1:0] rd_t_reg;
    logic [QUO_W-1:0] rd_t_next;

    logic                  ds_hit_reg;
    cvec_t                 ds_st_reg;
    uvec_t                 ds_dn_reg;
    logic signed [E_W-1:0] ds_dist_reg;
    logic signed [P_W-1:0] dist_prod;

    logic                  of_hit_reg;
    cvec_t                 of_st_reg;
    logic signed [P_W-1:0] of_off_reg [3];

    logic [BACK_N-1:0] bv_reg;
    logic              res_valid_reg;
    res_t              res_reg;
    res_t              res_next;
    logic              eb;

    // Hold everything while a result waits and the consumer stalls.
    assign eb        = !(res_valid_reg && res_stall);
    assign pop       = eb && q_status.avail;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        logic [REM_W-1:0] r2;
        dv_rem_next[0] = dv_rem_reg[0];
        dv_t_next[0]   = dv_t_reg[0];
        for (int j = 1; j <= FRAC_W; j++)
        begin
            r2 = {dv_rem_reg[j-1][REM_W-2:0], 1'b0};
            if (r2 >= REM_W'(dv_den_reg[j-1]))
            begin
                dv_rem_next[j] = r2 - REM_W'(dv_den_reg[j-1]);
                dv_t_next[j]   = {dv_t_reg[j-1][FRAC_W-2:0], 1'b1};
            end
            else
            begin
                dv_rem_next[j] = r2;
                dv_t_next[j]   = {dv_t_reg[j-1][FRAC_W-2:0], 1'b0};
            end
        end
    end

    // Round half up; a zero denominator means the two distances were equal.
    always_comb
    begin
        logic [REM_W:0] r2x;
        r2x = {dv_rem_reg[FRAC_W], 1'b0};
        if (dv_den_reg[FRAC_W] == '0)
            rd_t_next = '0;
        else
            rd_t_next = QUO_W'(dv_t_reg[FRAC_W])
                      + QUO_W'(r2x >= (REM_W+1)'(dv_den_reg[FRAC_W]));
    end

    assign dist_prod = qmul_unit(unit_t'({1'b0, rd_t_reg}), E_W'(rd_len_reg));

    always_comb
    begin
        res_next.hit = of_hit_reg;
        res_next.point_x = of_hit_reg
            ? sat_coord(SAT_W'($signed(of_st_reg[0])) + SAT_W'(of_off_reg[0])) : '0;
        res_next.point_y = of_hit_reg
            ? sat_coord(SAT_W'($signed(of_st_reg[1])) + SAT_W'(of_off_reg[1])) : '0;
        res_next.point_z = of_hit_reg
            ? sat_coord(SAT_W'($signed(of_st_reg[2])) + SAT_W'(of_off_reg[2])) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (eb)
        begin
            bv_reg        <= {bv_reg[BACK_N-2:0], q_status.avail};
            res_valid_reg <= bv_reg[BACK_N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (eb)
        begin
            dv_hit_reg[0] <= job.hit;
            dv_st_reg[0]  <= job.st;
            dv_dn_reg[0]  <= job.dn;
            dv_len_reg[0] <= job.len;
            dv_den_reg[0] <= job.den;
            dv_rem_reg[0] <= REM_W'($unsigned(job.p1));
            dv_t_reg[0]   <= '0;
            for (int j = 1; j <= FRAC_W; j++)
            begin
                dv_hit_reg[j] <= dv_hit_reg[j-1];
                dv_st_reg[j]  <= dv_st_reg[j-1];
                dv_dn_reg[j]  <= dv_dn_reg[j-1];
                dv_len_reg[j] <= dv_len_reg[j-1];
                dv_den_reg[j] <= dv_den_reg[j-1];
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_t_reg[j]   <= dv_t_next[j];
            end

            rd_hit_reg <= dv_hit_reg[FRAC_W];
            rd_st_reg  <= dv_st_reg[FRAC_W];
            rd_dn_reg  <= dv_dn_reg[FRAC_W];
            rd_len_reg <= dv_len_reg[FRAC_W];
            rd_t_reg   <= rd_t_next;

            ds_hit_reg  <= rd_hit_reg;
            ds_st_reg   <= rd_st_reg;
            ds_dn_reg   <= rd_dn_reg;
            ds_dist_reg <= dist_prod[E_W-1:0];

            of_hit_reg <= ds_hit_reg;
            of_st_reg  <= ds_st_reg;
            for (int i = 0; i < 3; i++)
                of_off_reg[i] <= qmul_unit(ds_dn_reg[i], ds_dist_reg);

            res_reg <= res_next;
        end
    end

endmodule

// ===== hw/rtl/segment_plane_intersect.sv =====
// Top level of the segment / plane crossing test: configuration registers,
// front part, item queue and back part.
// Depends on spi_pkg, spi_front, spi_queue and spi_back.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+---------------------------------
//  seg     | seg_valid / seg_stall       | seg_t: start, direction, length
//  res     | res_valid / res_stall       | res_t: hit flag, crossing point
//  cfg     | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// One item per cycle while res_stall stays low; the depth is set by the two
// bit-serial stage chains of the normaliser (square root and division) in the
// front and the 16-stage ratio division in the back.
// Reset clears the pipeline valids, the queue and the output valid flag, and
// loads the plane registers with a unit z normal through the origin and a
// margin of 7 LSBs.
// A stalled result holds the back part; the 4-item queue then fills and only
// after that does the front raise seg_stall.
module segment_plane_intersect
    import spi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 seg_valid,
    output logic                 seg_stall,
    input  seg_t                 seg,
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_t                 res,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    cvec_t               normal_reg;
    cvec_t               point_reg;
    logic [MARGIN_W-1:0] margin_reg;

    logic      push;
    logic      pop;
    job_t      front_job;
    job_t      queue_job;
    q_status_t q_status;

    // Always writable; writes must come while the block idles, unenforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg <= {ONE_Q, coord_t'(0), coord_t'(0)};
            point_reg  <= '0;
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_NORMAL_X: normal_reg[0] <= cfg_data;
                CFG_NORMAL_Y: normal_reg[1] <= cfg_data;
                CFG_NORMAL_Z: normal_reg[2] <= cfg_data;
                CFG_POINT_X:  point_reg[0]  <= cfg_data;
                CFG_POINT_Y:  point_reg[1]  <= cfg_data;
                CFG_POINT_Z:  point_reg[2]  <= cfg_data;
                CFG_MARGIN:   margin_reg    <= cfg_data[MARGIN_W-1:0];
                default:      ;  // drop writes beyond the register list
            endcase
        end
    end

    // Normalise, measure both plane distances and classify each segment.
    spi_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .seg_valid   (seg_valid),
        .seg         (seg),
        .seg_stall   (seg_stall),
        .normal      (normal_reg),
        .plane_point (point_reg),
        .margin      (margin_reg),
        .q_status    (q_status),
        .push        (push),
        .job         (front_job)
    );

    // Decouple the two parts so each can stall on its own.
    spi_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (front_job),
        .pop    (pop),
        .rd_job (queue_job),
        .status (q_status)
    );

    // Work out the crossing point and present the result.
    spi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (queue_job),
        .q_status  (q_status),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for segment_plane_intersect: random and directed segments
// against a built-in bit-exact predictor, with random idling on both sides.
// Depends on spi_pkg and the segment_plane_intersect RTL.
module tb;
    import spi_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_ITEMS   = 1100;

    logic                 clk;
    logic                 rst_n;
    logic                 seg_valid;
    logic                 seg_stall;
    seg_t                 seg;
    logic                 res_valid;
    logic                 res_stall;
    res_t                 res;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;

    segment_plane_intersect DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg       (seg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Plane registers as the predictor sees them; updated alongside each write.
    logic signed [63:0] plane_n [3];
    logic signed [63:0] plane_p [3];
    logic [15:0]        margin;

    seg_t pending_segs [$];
    res_t expected_hits [$];
    int   error_count;
    int   sent_count;
    int   idle_cycles;
    int   gap_left;
    int   stall_left;
    bit   driving_done;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Magnitude of a signed 64-bit value.
    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    // Fixed-point product, rounded half away from zero, capped at 2^60.
    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic [127:0] prod;
        logic [127:0] q;
        prod = {64'd0, mag64(a)} * {64'd0, mag64(b)};
        prod = prod + (128'd1 << (FRAC_W - 1));
        q    = prod >> FRAC_W;
        if (q > (128'd1 << 60))
            q = 128'd1 << 60;
        return ((a < 0) != (b < 0)) ? -$signed(64'(q)) : $signed(64'(q));
    endfunction

    function automatic logic signed [63:0] clamp_coord(input logic signed [63:0] x);
        logic signed [63:0] hi;
        hi = (64'sd1 <<< (COORD_W - 1)) - 1;
        if (x > hi)
            return hi;
        if (x < -hi - 1)
            return -hi - 1;
        return x;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // Scale a vector to unit length in Q.FRAC_W; a zero vector stays zero.
    task automatic unit_vector(input logic signed [63:0] v [3],
                               output logic signed [63:0] u [3]);
        logic [63:0] biggest;
        logic [63:0] a [3];
        logic [63:0] sumsq;
        logic [63:0] root;
        logic [63:0] c;
        int          sh;
        biggest = 0;
        sumsq   = 0;
        sh      = 0;
        for (int i = 0; i < 3; i++)
            if (mag64(v[i]) > biggest)
                biggest = mag64(v[i]);
        while ((biggest >> sh) >= (64'd1 << 30))
            sh++;
        for (int i = 0; i < 3; i++)
        begin
            a[i]  = mag64(v[i]) >> sh;
            sumsq = sumsq + a[i] * a[i];
        end
        root = int_sqrt(sumsq);
        for (int i = 0; i < 3; i++)
        begin
            c    = root == 0 ? 64'd0 : ((a[i] << FRAC_W) + root / 2) / root;
            u[i] = v[i] < 0 ? -$signed(c) : $signed(c);
        end
    endtask

    // Work out the crossing result for one segment under the current plane.
    task automatic predict_crossing(input seg_t s, output res_t r);
        logic signed [63:0] st [3];
        logic signed [63:0] dr [3];
        logic signed [63:0] dn [3];
        logic signed [63:0] nn [3];
        logic signed [63:0] d [3];
        logic signed [63:0] e [3];
        logic signed [63:0] pt [3];
        logic signed [63:0] len;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
        logic signed [63:0] eps;
        logic signed [63:0] travel;
        logic [63:0]        den;
        logic [63:0]        rem;
        logic [63:0]        t;
        st  = '{s.start_x, s.start_y, s.start_z};
        dr  = '{s.dir_x, s.dir_y, s.dir_z};
        len = {33'd0, s.seg_length};
        eps = {48'd0, margin};
        pt  = '{0, 0, 0};
        unit_vector(dr, dn);
        unit_vector(plane_n, nn);
        for (int i = 0; i < 3; i++)
        begin
            d[i] = st[i] - plane_p[i];
            e[i] = d[i] + fx_mul(dn[i], len);
        end
        p1 = clamp_coord(fx_mul(nn[0], d[0]) + fx_mul(nn[1], d[1]) + fx_mul(nn[2], d[2]));
        p2 = clamp_coord(fx_mul(nn[0], e[0]) + fx_mul(nn[1], e[1]) + fx_mul(nn[2], e[2]));
        r.hit = 1'b0;
        if (p1 >= eps && p2 <= -eps)
        begin
            r.hit = 1'b1;
            den   = 64'(p1 - p2);
            rem   = 64'(p1);
            t     = 0;
            if (den != 0)
            begin
                for (int i = 0; i < FRAC_W; i++)
                begin
                    rem = rem << 1;
                    t   = t << 1;
                    if (rem >= den)
                    begin
                        rem = rem - den;
                        t   = t | 64'd1;
                    end
                end
                if (2 * rem >= den)
                    t++;
            end
            travel = fx_mul(len, $signed(t));
            for (int i = 0; i < 3; i++)
                pt[i] = clamp_coord(st[i] + fx_mul(dn[i], travel));
        end
        r.point_x = coord_t'(pt[0]);
        r.point_y = coord_t'(pt[1]);
        r.point_z = coord_t'(pt[2]);
    endtask

    // Random coordinate: mostly modest values, sometimes full range or extremes.
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 9))
            0:       return coord_t'($urandom);
            1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2:       return '0;
            default: return coord_t'($signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000);
        endcase
    endfunction

    function automatic seg_t rand_seg();
        seg_t s;
        s.start_x = rand_coord();
        s.start_y = rand_coord();
        s.start_z = rand_coord();
        s.dir_x   = rand_coord();
        s.dir_y   = rand_coord();
        s.dir_z   = rand_coord();
        case ($urandom_range(0, 5))
            0:       s.seg_length = LEN_W'($urandom);
            1:       s.seg_length = '1;
            default: s.seg_length = LEN_W'($urandom_range(0, 32'h02000000));
        endcase
        return s;
    endfunction

    // Well-formed crossing: start in front of a z-ish plane, heading through it.
    function automatic seg_t crossing_seg();
        seg_t s;
        s = rand_seg();
        s.start_z    = coord_t'(plane_p[2] + 64'($urandom_range(1, 32'h00400000)));
        s.dir_z      = -coord_t'($urandom_range(1, 32'h00100000));
        s.seg_length = LEN_W'($urandom_range(32'h00800000, 32'h04000000));
        return s;
    endfunction

    // Write one register and leave valid high; the caller drops it after the
    // last write. The bench only calls this with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < CFG_MARGIN)
        begin
            if (idx < CFG_POINT_X)
                plane_n[idx] = $signed(val);
            else
                plane_p[idx - CFG_POINT_X] = $signed(val);
        end
        else if (idx == CFG_MARGIN)
            margin = val[15:0];
    endtask

    // Hold until every queued item is sent and every result returned, then settle.
    task automatic wait_idle();
        while (pending_segs.size() != 0 || expected_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_plane(input logic [31:0] nx, input logic [31:0] ny,
                             input logic [31:0] nz, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz,
                             input logic [31:0] eps);
        wait_idle();
        write_reg(CFG_NORMAL_X, nx);
        write_reg(CFG_NORMAL_Y, ny);
        write_reg(CFG_NORMAL_Z, nz);
        write_reg(CFG_POINT_X, px);
        write_reg(CFG_POINT_Y, py);
        write_reg(CFG_POINT_Z, pz);
        write_reg(CFG_MARGIN, eps);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            pending_segs.push_back($urandom_range(0, 9) < 6 ? crossing_seg() : rand_seg());
    endtask

    // Driver: present queued items with random gaps, holding a stalled item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_valid <= 1'b0;
            seg       <= '0;
            gap_left  <= 0;
        end
        else if (seg_valid && seg_stall)
        begin
            // hold
        end
        else
        begin
            if (seg_valid)
            begin
                res_t r;
                predict_crossing(seg, r);
                expected_hits.push_back(r);
                void'(pending_segs.pop_front());
            end
            if (gap_left > 0)
            begin
                gap_left  <= gap_left - 1;
                seg_valid <= 1'b0;
            end
            else if (pending_segs.size() > 0)
            begin
                seg_valid <= 1'b1;
                seg       <= pending_segs[0];
                case ($urandom_range(0, 19))
                    0:       gap_left <= $urandom_range(10, 40);
                    1, 2, 3: gap_left <= $urandom_range(1, 3);
                    default: gap_left <= 0;
                endcase
            end
            else
                seg_valid <= 1'b0;
        end
    end

    // Monitor: compare each accepted result with the oldest prediction; idle at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_hits.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, res);
                    error_count++;
                end
                else
                begin
                    res_t exp_r;
                    exp_r = expected_hits.pop_front();
                    if (res.hit !== exp_r.hit)
                    begin
                        $display("%0t: hit expected %0b got %0b", $time, exp_r.hit, res.hit);
                        error_count++;
                    end
                    if (res.point_x !== exp_r.point_x)
                    begin
                        $display("%0t: point_x expected %0d got %0d", $time,
                                 exp_r.point_x, res.point_x);
                        error_count++;
                    end
                    if (res.point_y !== exp_r.point_y)
                    begin
                        $display("%0t: point_y expected %0d got %0d", $time,
                                 exp_r.point_y, res.point_y);
                        error_count++;
                    end
                    if (res.point_z !== exp_r.point_z)
                    begin
                        $display("%0t: point_z expected %0d got %0d", $time,
                                 exp_r.point_z, res.point_z);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                res_stall  <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
                case ($urandom_range(0, 19))
                    0:       stall_left <= $urandom_range(10, 60);
                    1, 2, 3: stall_left <= $urandom_range(1, 3);
                    default: stall_left <= 0;
                endcase
            end
        end
    end

    // Watchdog: give up once nothing has moved on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (seg_valid && !seg_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        seg_t s;
        error_count = 0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        plane_n     = '{0, 0, 65536};
        plane_p     = '{0, 0, 0};
        margin      = 16'd7;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset plane, field extremes, zero vectors, plain crossings.
        s = '{default: '0};
        pending_segs.push_back(s);
        s = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh80000000, 32'sh80000000, 32'sh80000000, '1};
        pending_segs.push_back(s);
        s = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, '1};
        pending_segs.push_back(s);
        s = '{0, 0, 32'sh00010000, 0, 0, 32'shffff0000, 31'h00020000};
        pending_segs.push_back(s);
        s = '{32'sh00030000, -32'sh00020000, 32'sh00050000,
              32'sh00010000, 32'sh00010000, -32'sh00040000, 31'h000a0000};
        pending_segs.push_back(s);
        s = '{0, 0, 32'sh00010000, 0, 0, 0, 31'h00100000};
        pending_segs.push_back(s);
        s = '{0, 0, 32'sh00000007, 0, 0, -32'sh00000001, 31'h0000000e};
        pending_segs.push_back(s);
        s = '{0, 0, 32'sh00000006, 0, 0, -32'sh00000001, 31'h0000000e};
        pending_segs.push_back(s);
        s = '{0, 0, -32'sh00010000, 0, 0, 32'sh00010000, 31'h00020000};
        pending_segs.push_back(s);
        s = '{32'sh12345678, 32'shedcba987, 32'sh7fff0000,
              0, 0, 32'sh80000000, '1};
        pending_segs.push_back(s);

        // Zero margin with a zero normal: every segment counts as a crossing.
        set_plane(0, 0, 0, 0, 0, 0, 0);
        s = '{32'sh00010000, 32'sh00020000, 32'sh00030000, 0, 0, 0, 31'h00010000};
        pending_segs.push_back(s);
        s = '{-32'sh00010000, 0, 32'sh7fffffff, 32'sh00010000, 0, 0, 31'h7fff0000};
        pending_segs.push_back(s);
        s = '{0, 0, 0, 0, 0, 0, 0};
        pending_segs.push_back(s);

        // Full margin, tilted plane at an offset.
        set_plane(32'h00010000, 32'h00010000, 32'h00010000,
                  32'h00020000, 32'hfffe0000, 32'h00010000, 32'h0000ffff);
        random_phase(RANDOM_ITEMS / 4);

        // Extreme register values.
        set_plane(32'h80000000, 32'h7fffffff, 32'h80000000,
                  32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h00000000);
        random_phase(RANDOM_ITEMS / 8);

        // Back to a z plane with a random offset and margin; most traffic crosses.
        set_plane(0, 0, $urandom_range(1, 32'h7fffffff),
                  $urandom, $urandom, $urandom_range(0, 32'h00ffffff) - 32'h00800000,
                  $urandom_range(0, 65535));
        random_phase(RANDOM_ITEMS / 2);

        set_plane($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 32'd7);
        random_phase(RANDOM_ITEMS / 8);

        wait_idle();
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/spi_pkg.sv
hw/rtl/spi_norm.sv
hw/rtl/spi_front.sv
hw/rtl/spi_queue.sv
hw/rtl/spi_back.sv
hw/rtl/segment_plane_intersect.sv
verif/tb.sv
